// File: rtl/ksl_pkg.sv
// ----------------------------------------------------------------------------
// Keyed slot table package
// Shared types and constants for the keyed slot table and its slot cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksl_pkg;

  localparam int SLOT_COUNT_DEF   = 16;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int ID_W             = 15;
  localparam int HDR_W_MAX        = 64;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_GET    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic                 valid;
    logic                 done;
    mode_t                mode;
    logic [ID_W-1:0]      item_id;
    logic [HDR_W_MAX-1:0] header_word;
    logic                 found;
    logic [ID_W-1:0]      id_out;
    logic [HDR_W_MAX-1:0] header_out;
    status_t              status;
  } beat_t;

endpackage

// File: rtl/ksl_if.sv
// ----------------------------------------------------------------------------
// Keyed slot table channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksl_req_if import ksl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [ID_W-1:0]      item_id;
  logic [HDR_W_MAX-1:0] header_word;

  modport source (output valid, output mode, output item_id, output header_word,
                  input ready);
  modport sink (input valid, input mode, input item_id, input header_word,
                output ready);
endinterface

interface ksl_rsp_if import ksl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [ID_W-1:0]      id_out;
  logic [HDR_W_MAX-1:0] header_out;
  logic [1:0]           status;

  modport source (output valid, output found, output id_out, output header_out,
                  output status, input ready);
  modport sink (input valid, input found, input id_out, input header_out,
                input status, output ready);
endinterface

// File: rtl/ksl_cell.sv
// ----------------------------------------------------------------------------
// Keyed slot table cell
// Holds one slot and registers the beat passing through it toward the next
// cell, applying the beat's operation if no earlier cell has taken it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksl_cell import ksl_pkg::*; #(
  parameter int HDR_W = HDR_W_MAX
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  beat_t beat_in,
  output beat_t beat_out
);

  logic             used;
  logic [ID_W-1:0]  sid;
  logic [HDR_W-1:0] shdr;

  logic  used_next;
  logic  slot_write;
  beat_t beat_next;
  logic  id_hit;
  logic  hdr_hit;
  logic  live;

  assign live    = beat_in.valid && !beat_in.done;
  assign id_hit  = used && (sid == beat_in.item_id);
  assign hdr_hit = used && (shdr == beat_in.header_word[HDR_W-1:0]);

  always_comb begin
    beat_next  = beat_in;
    used_next  = used;
    slot_write = 1'b0;
    if (live) begin
      case (beat_in.mode)
        MODE_INSERT: begin
          if (!used) begin
            used_next        = 1'b1;
            slot_write       = 1'b1;
            beat_next.done   = 1'b1;
            beat_next.status = ST_DONE;
          end
        end
        MODE_REMOVE: begin
          if (id_hit) begin
            used_next        = 1'b0;
            beat_next.done   = 1'b1;
            beat_next.found  = 1'b1;
            beat_next.status = ST_DONE;
          end
        end
        MODE_FIND: begin
          if (hdr_hit) begin
            beat_next.done   = 1'b1;
            beat_next.found  = 1'b1;
            beat_next.id_out = sid;
            beat_next.status = ST_DONE;
          end
        end
        MODE_GET: begin
          if (id_hit) begin
            beat_next.done       = 1'b1;
            beat_next.found      = 1'b1;
            beat_next.header_out = HDR_W_MAX'(shdr);
            beat_next.status     = ST_DONE;
          end
        end
        default: begin
          beat_next = beat_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= 1'b0;
      beat_out.valid <= 1'b0;
    end else if (advance) begin
      used     <= used_next;
      beat_out <= beat_next;
      if (slot_write) begin
        sid  <= beat_in.item_id;
        shdr <= beat_in.header_word[HDR_W-1:0];
      end
    end
  end

endmodule

// File: rtl/keyed_slot_table.sv
// ----------------------------------------------------------------------------
// Keyed slot table
// Throughput: one request per cycle while the response is not stalled; each beat steps one slot cell per cycle.
// A stalled response holds the whole row of cells in place.
// Reset marks every slot free; stored ids and headers are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_slot_table import ksl_pkg::*; #(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ksl_req_if.sink   req,
  ksl_rsp_if.source rsp
);

  localparam int HDR_W = HEADER_BYTES * 8;
  localparam logic [HDR_W_MAX-1:0] HDR_MASK = {HDR_W_MAX{1'b1}} >> (HDR_W_MAX - HDR_W);

  beat_t chain [SLOT_COUNT+1];
  beat_t head;
  beat_t last_beat;
  logic  advance;

  assign last_beat = chain[SLOT_COUNT];
  assign advance   = !last_beat.valid || rsp.ready;
  assign req.ready = advance;

  always_comb begin
    head.valid       = req.valid;
    head.done        = 1'b0;
    head.mode        = mode_t'(req.mode);
    head.item_id     = req.item_id;
    head.header_word = req.header_word & HDR_MASK;
    head.found       = 1'b0;
    head.id_out      = '0;
    head.header_out  = '0;
    head.status      = (mode_t'(req.mode) == MODE_INSERT) ? ST_FULL : ST_NO_MATCH;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ksl_cell #(
      .HDR_W (HDR_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  assign rsp.valid      = last_beat.valid;
  assign rsp.found      = last_beat.found;
  assign rsp.id_out     = last_beat.id_out;
  assign rsp.header_out = last_beat.header_out;
  assign rsp.status     = last_beat.status;

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("Response beat present right after reset.");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == ST_DONE)
    else $error("Matched beat without done status.");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> !rsp.found && last_beat.mode == MODE_INSERT)
    else $error("Full status on a beat that is not an unplaced insert.");

  a_id_needs_find: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.id_out != '0 |-> rsp.found && last_beat.mode == MODE_FIND)
    else $error("Id returned without a header match.");

  a_hdr_needs_get: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.header_out != '0 |-> rsp.found && last_beat.mode == MODE_GET)
    else $error("Header returned without an id match.");

endmodule
